>>> design/dlxeu_pkg.sv
// Shared constants, command codes and memory request type for the DLX-subset execute unit.
package dlxeu_pkg;

  localparam int ADDR_BITS = 16;
  localparam int NUM_REGS  = 32;
  localparam int PC_BITS   = 12;
  localparam int REG_BITS  = $clog2(NUM_REGS);
  localparam int NUM_BANKS = 4;
  localparam int ROW_BITS  = ADDR_BITS - 2;
  localparam int LEN_BITS  = 13;

  localparam logic [5:0] CMD_ADD     = 6'd0;
  localparam logic [5:0] CMD_XOR     = 6'd4;
  localparam logic [5:0] CMD_ADDI    = 6'd5;
  localparam logic [5:0] CMD_XORI    = 6'd9;
  localparam logic [5:0] CMD_SLT     = 6'd10;
  localparam logic [5:0] CMD_SNE     = 6'd15;
  localparam logic [5:0] CMD_SLTI    = 6'd16;
  localparam logic [5:0] CMD_SNEI    = 6'd21;
  localparam logic [5:0] CMD_SLLI    = 6'd22;
  localparam logic [5:0] CMD_SRLI    = 6'd23;
  localparam logic [5:0] CMD_LW      = 6'd24;
  localparam logic [5:0] CMD_SW      = 6'd25;
  localparam logic [5:0] CMD_LB      = 6'd26;
  localparam logic [5:0] CMD_SB      = 6'd27;
  localparam logic [5:0] CMD_BEQZ    = 6'd28;
  localparam logic [5:0] CMD_BNEZ    = 6'd29;
  localparam logic [5:0] CMD_JR      = 6'd30;
  localparam logic [5:0] CMD_PRINT   = 6'd31;
  localparam logic [5:0] CMD_PRELOAD = 6'd32;

  localparam logic [1:0] TM_LABEL = 2'd0;
  localparam logic [1:0] TM_REG   = 2'd1;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_OR  = 3'd3;

  localparam logic [2:0] CMP_LT = 3'd0;
  localparam logic [2:0] CMP_LE = 3'd1;
  localparam logic [2:0] CMP_EQ = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;
  localparam logic [2:0] CMP_GE = 3'd4;

  // One access to the byte banks: per-bank enable, write, row and data.
  typedef struct packed {
    logic [NUM_BANKS-1:0]               en;
    logic [NUM_BANKS-1:0]               we;
    logic [NUM_BANKS-1:0][ROW_BITS-1:0] row;
    logic [NUM_BANKS-1:0][7:0]          wdata;
  } dmem_req_t;

  function automatic logic [REG_BITS-1:0] reg_index(input logic [4:0] f);
    return REG_BITS'(32'(f) % NUM_REGS);
  endfunction

endpackage

>>> design/dlx_subset_execute_unit.sv
// The register file read and the byte-bank data memory read are both registered, and
// one instruction is in flight: no new beat is taken while the last one is still in
// the execute stage or has not yet left the writeback stage.
// Reset: synchronous; pc, registers and program_length clear at once, and the data
// memory sweeps its 2**(ADDR_BITS-2) = 16384 rows to zero with no input taken.
module dlx_subset_execute_unit import dlxeu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [5:0]          command,
  input  logic [4:0]          dest_reg,
  input  logic [4:0]          src_reg_a,
  input  logic [4:0]          src_reg_b,
  input  logic signed [31:0]  immediate,
  input  logic [1:0]          target_mode,
  input  logic [11:0]         target_index,
  input  logic                print_from_register,
  input  logic [7:0]          byte_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  next_pc,
  output logic                print_valid,
  output logic signed [31:0]  print_value,
  output logic                finished
);

  logic [LEN_BITS-1:0] program_length;
  logic [31:0]         pc;

  // Execute stage
  logic                s1_valid;
  logic [5:0]          s1_cmd;
  logic [REG_BITS-1:0] s1_rd;
  logic [REG_BITS-1:0] s1_ra;
  logic [31:0]         s1_imm;
  logic [1:0]          s1_mode;
  logic [PC_BITS-1:0]  s1_label;
  logic                s1_from_reg;
  logic [7:0]          s1_byte;

  // Memory / writeback stage
  logic                s2_valid;
  logic                s2_wb_en;
  logic                s2_ld_word;
  logic                s2_ld_byte;
  logic [REG_BITS-1:0] s2_rd;
  logic [31:0]         s2_val;
  logic [1:0]          s2_alo;
  logic                s2_pvalid;
  logic                s2_pmem;
  logic [31:0]         s2_next;
  logic                s2_fin;

  logic                accept, s1_adv, s2_adv;
  logic                uses_rd;
  logic [REG_BITS-1:0] raddr1;
  logic [31:0]         va, vp;
  logic                rf_we;
  logic [31:0]         rf_wdata;
  dmem_req_t           mreq;
  logic [NUM_BANKS-1:0][7:0] mq;
  logic                mem_busy;

  // Execute results
  logic [31:0]          opnd, alu_res, wb_val, next, maddr32;
  logic [2:0]           alu_kind, cmp_kind;
  logic                 cmp_res, wb_en, ld_word, ld_byte, rd_mem, wr_word, wr_byte;
  logic                 pvalid, pmem, taken, fin;
  logic [ADDR_BITS-1:0] maddr;
  logic [7:0]           st_byte;
  logic [31:0]          ld_word_val;

  assign s2_adv   = s2_valid && (!out_valid || out_ready);
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign in_ready = !mem_busy && !s1_valid && (!s2_valid || s2_adv);
  assign accept   = in_valid && in_ready;

  assign uses_rd = command inside {CMD_SW, CMD_SB, CMD_BEQZ, CMD_BNEZ};
  assign raddr1  = uses_rd ? reg_index(dest_reg) : reg_index(src_reg_b);

  dlxeu_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .raddr0 (reg_index(src_reg_a)),
    .raddr1 (raddr1),
    .we     (rf_we),
    .waddr  (s2_rd),
    .wdata  (rf_wdata),
    .rdata0 (va),
    .rdata1 (vp)
  );

  dlxeu_datamem u_datamem (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .q    (mq),
    .busy (mem_busy)
  );

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  // Capture an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= command;
      s1_rd       <= reg_index(dest_reg);
      s1_ra       <= reg_index(src_reg_a);
      s1_imm      <= immediate;
      s1_mode     <= target_mode;
      s1_label    <= target_index[PC_BITS-1:0];
      s1_from_reg <= print_from_register;
      s1_byte     <= byte_data;
    end
  end

  // Operand select and operation kinds
  always_comb begin
    if (s1_cmd <= CMD_XOR || (s1_cmd >= CMD_SLT && s1_cmd <= CMD_SNE)) begin
      opnd = vp;
    end else begin
      opnd = s1_imm;
    end
    alu_kind = (s1_cmd <= CMD_XOR) ? s1_cmd[2:0] : 3'(s1_cmd - CMD_ADDI);
    cmp_kind = (s1_cmd <= CMD_SNE) ? 3'(s1_cmd - CMD_SLT) : 3'(s1_cmd - CMD_SLTI);
  end

  always_comb begin
    case (alu_kind)
      ALU_ADD: alu_res = va + opnd;
      ALU_SUB: alu_res = va - opnd;
      ALU_AND: alu_res = va & opnd;
      ALU_OR:  alu_res = va | opnd;
      default: alu_res = va ^ opnd;
    endcase
    case (cmp_kind)
      CMP_LT:  cmp_res = $signed(va) <  $signed(opnd);
      CMP_LE:  cmp_res = $signed(va) <= $signed(opnd);
      CMP_EQ:  cmp_res = va == opnd;
      CMP_GT:  cmp_res = $signed(va) >  $signed(opnd);
      CMP_GE:  cmp_res = $signed(va) >= $signed(opnd);
      default: cmp_res = va != opnd;
    endcase
  end

  // Decode the command into writeback, memory and flow actions
  always_comb begin
    wb_en   = 1'b0;
    wb_val  = alu_res;
    ld_word = 1'b0;
    ld_byte = 1'b0;
    rd_mem  = 1'b0;
    wr_word = 1'b0;
    wr_byte = 1'b0;
    pvalid  = 1'b0;
    pmem    = 1'b0;
    taken   = 1'b0;
    next    = pc + 32'd1;
    st_byte = vp[7:0];
    if (s1_cmd inside {[CMD_ADD:CMD_XORI]}) begin
      wb_en = 1'b1;
    end else if (s1_cmd inside {[CMD_SLT:CMD_SNEI]}) begin
      wb_en  = 1'b1;
      wb_val = {31'b0, cmp_res};
    end else begin
      case (s1_cmd)
        CMD_SLLI: begin
          wb_en  = 1'b1;
          wb_val = va << s1_imm[4:0];
        end
        CMD_SRLI: begin
          wb_en  = 1'b1;
          wb_val = va >> s1_imm[4:0];
        end
        CMD_LW: begin
          wb_en   = 1'b1;
          ld_word = 1'b1;
          rd_mem  = 1'b1;
        end
        CMD_LB: begin
          wb_en   = 1'b1;
          ld_byte = 1'b1;
          rd_mem  = 1'b1;
        end
        CMD_SW: wr_word = 1'b1;
        CMD_SB: wr_byte = 1'b1;
        CMD_BEQZ, CMD_BNEZ: begin
          taken = (s1_cmd == CMD_BEQZ) ? (vp == '0) : (vp != '0);
          if (taken) begin
            next = (s1_mode == TM_LABEL) ? 32'(s1_label) : pc + s1_imm + 32'd1;
          end
        end
        CMD_JR: begin
          if (s1_mode == TM_LABEL) begin
            next = 32'(s1_label);
          end else if (s1_mode == TM_REG) begin
            next = pc + va;
          end else begin
            next = pc + s1_imm;
          end
        end
        CMD_PRINT: begin
          pvalid = 1'b1;
          wb_val = va;
          if (!s1_from_reg) begin
            pmem   = 1'b1;
            rd_mem = 1'b1;
          end
        end
        CMD_PRELOAD: begin
          wr_byte = 1'b1;
          st_byte = s1_byte;
          next    = pc;
        end
        default: ;
      endcase
    end
    fin = $signed(next) >= $signed({{(32-LEN_BITS){1'b0}}, program_length});
  end

  // Byte address: immediate alone for preload and absolute print
  assign maddr32 = (s1_cmd == CMD_PRELOAD || (s1_cmd == CMD_PRINT && s1_ra == '0))
                   ? s1_imm : va + s1_imm;
  assign maddr   = maddr32[ADDR_BITS-1:0];

  // Spread a word access over the banks, each byte to its own row
  always_comb begin
    logic [1:0]           i;
    logic [ADDR_BITS-1:0] badr;
    mreq = '0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      i                = 2'(k) - maddr[1:0];
      badr             = maddr + ADDR_BITS'(i);
      mreq.row[k]      = badr[ADDR_BITS-1:2];
      mreq.wdata[k]    = wr_byte ? st_byte : 8'(vp >> {~i, 3'b000});
      mreq.we[k]       = wr_word || wr_byte;
      mreq.en[k]       = s1_adv && (rd_mem || wr_word || (wr_byte && 2'(k) == maddr[1:0]));
    end
  end

  // Advance the program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_adv) begin
      pc <= next;
    end
  end

  // Advance to the writeback stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_wb_en   <= wb_en;
      s2_ld_word <= ld_word;
      s2_ld_byte <= ld_byte;
      s2_rd      <= s1_rd;
      s2_val     <= wb_val;
      s2_alo     <= maddr[1:0];
      s2_pvalid  <= pvalid;
      s2_pmem    <= pmem;
      s2_next    <= next;
      s2_fin     <= fin;
    end
  end

  // Reassemble the big-endian word from the banks
  assign ld_word_val = {mq[s2_alo], mq[2'(s2_alo + 2'd1)],
                        mq[2'(s2_alo + 2'd2)], mq[2'(s2_alo + 2'd3)]};

  always_comb begin
    if (s2_ld_word) begin
      rf_wdata = ld_word_val;
    end else if (s2_ld_byte) begin
      rf_wdata = {24'b0, mq[s2_alo]};
    end else begin
      rf_wdata = s2_val;
    end
  end

  assign rf_we = s2_adv && s2_wb_en;

  // Load the output register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      next_pc     <= s2_next;
      print_valid <= s2_pvalid;
      print_value <= !s2_pvalid ? '0 : (s2_pmem ? ld_word_val : s2_val);
      finished    <= s2_fin;
    end
  end

endmodule

>>> design/dlxeu_regfile.sv
// Register file: two registered read ports, one write port, reset valid bits, write bypass.
module dlxeu_regfile import dlxeu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [REG_BITS-1:0] raddr0,
  input  logic [REG_BITS-1:0] raddr1,
  input  logic                we,
  input  logic [REG_BITS-1:0] waddr,
  input  logic [31:0]         wdata,
  output logic [31:0]         rdata0,
  output logic [31:0]         rdata1
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;

  // Write the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Read both ports, forwarding a write at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0 <= (we && waddr == raddr0) ? wdata : (valid[raddr0] ? mem[raddr0] : '0);
      rdata1 <= (we && waddr == raddr1) ? wdata : (valid[raddr1] ? mem[raddr1] : '0);
    end
  end

endmodule

>>> design/dlxeu_datamem.sv
// Data memory: four byte banks interleaved on the low address bits, cleared after reset.
module dlxeu_datamem import dlxeu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dmem_req_t                 req,
  output logic [NUM_BANKS-1:0][7:0] q,
  output logic                      busy
);

  logic [ROW_BITS-1:0] clr_row;

  // Sweep every row once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == '1) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    logic [7:0] ram [2**ROW_BITS];

    // Clear, write, or read with held output
    always_ff @(posedge clk) begin
      if (busy) begin
        ram[clr_row] <= '0;
      end else if (req.en[k] && req.we[k]) begin
        ram[req.row[k]] <= req.wdata[k];
      end else if (req.en[k]) begin
        q[k] <= ram[req.row[k]];
      end
    end
  end

endmodule

>>> tb/dlxeu_checker.sv
// Checker for the DLX-subset execute unit: instruction predictor and result comparison.
module dlxeu_checker import dlxeu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [5:0]          command,
  input  logic [4:0]          dest_reg,
  input  logic [4:0]          src_reg_a,
  input  logic [4:0]          src_reg_b,
  input  logic signed [31:0]  immediate,
  input  logic [1:0]          target_mode,
  input  logic [11:0]         target_index,
  input  logic                print_from_register,
  input  logic [7:0]          byte_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [31:0]  next_pc,
  input  logic                print_valid,
  input  logic signed [31:0]  print_value,
  input  logic                finished,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] npc;
    logic        pv;
    logic [31:0] pval;
    logic        fin;
  } exec_result_t;

  logic [31:0]          pc_model;
  logic [31:0]          regs_model [NUM_REGS];
  logic [7:0]           mem_model [2**ADDR_BITS];
  logic [LEN_BITS-1:0]  len_model;
  exec_result_t         expected_q [$];

  assign pending_count = expected_q.size();

  function automatic logic [31:0] read_word(logic [31:0] a);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++)
      w = {w[23:0], mem_model[ADDR_BITS'(a + i)]};
    return w;
  endfunction

  function automatic logic cmp_signed(int kind, logic signed [31:0] x,
                                      logic signed [31:0] y);
    case (kind)
      0: return x < y;
      1: return x <= y;
      2: return x == y;
      3: return x > y;
      4: return x >= y;
      default: return x != y;
    endcase
  endfunction

  function automatic logic [31:0] alu_op(int kind, logic [31:0] x, logic [31:0] y);
    case (kind)
      0: return x + y;
      1: return x - y;
      2: return x & y;
      3: return x | y;
      default: return x ^ y;
    endcase
  endfunction

  // Execute one instruction against the model state and return its result.
  task automatic execute_instr(output exec_result_t r);
    logic [REG_BITS-1:0] rd, ra, rb;
    logic [31:0] va, vb, vd, imm, nxt, ea;
    rd = reg_index(dest_reg);
    ra = reg_index(src_reg_a);
    rb = reg_index(src_reg_b);
    va = regs_model[ra];
    vb = regs_model[rb];
    vd = regs_model[rd];
    imm = immediate;
    ea = va + imm;
    nxt = pc_model + 1;
    r = '0;
    if (command <= CMD_XOR) regs_model[rd] = alu_op(command, va, vb);
    else if (command <= CMD_XORI) regs_model[rd] = alu_op(command - CMD_ADDI, va, imm);
    else if (command <= CMD_SNE) regs_model[rd] = 32'(cmp_signed(command - CMD_SLT, va, vb));
    else if (command <= CMD_SNEI)
      regs_model[rd] = 32'(cmp_signed(command - CMD_SLTI, va, imm));
    else if (command == CMD_SLLI) regs_model[rd] = va << imm[4:0];
    else if (command == CMD_SRLI) regs_model[rd] = va >> imm[4:0];
    else if (command == CMD_LW) regs_model[rd] = read_word(ea);
    else if (command == CMD_SW) begin
      for (int i = 0; i < 4; i++)
        mem_model[ADDR_BITS'(ea + i)] = vd[31-8*i -: 8];
    end else if (command == CMD_LB) regs_model[rd] = 32'(mem_model[ADDR_BITS'(ea)]);
    else if (command == CMD_SB) mem_model[ADDR_BITS'(ea)] = vd[7:0];
    else if (command == CMD_BEQZ || command == CMD_BNEZ) begin
      if ((command == CMD_BEQZ) == (vd == 0))
        nxt = (target_mode == TM_LABEL) ? 32'(target_index) : pc_model + imm + 1;
    end else if (command == CMD_JR) begin
      if (target_mode == TM_LABEL) nxt = 32'(target_index);
      else if (target_mode == TM_REG) nxt = pc_model + va;
      else nxt = pc_model + imm;
    end else if (command == CMD_PRINT) begin
      r.pv = 1'b1;
      if (print_from_register) r.pval = va;
      else if (ra != 0) r.pval = read_word(ea);
      else r.pval = read_word(imm);
    end else if (command == CMD_PRELOAD) begin
      mem_model[ADDR_BITS'(imm)] = byte_data;
      nxt = pc_model;
    end
    pc_model = nxt;
    r.npc = nxt;
    r.fin = $signed(nxt) >= $signed({1'b0, 18'd0, len_model});
  endtask

  // Track configuration, predict accepted beats, compare result beats.
  always @(posedge clk) begin
    exec_result_t e, got;
    if (rst) begin
      pc_model = '0;
      foreach (regs_model[i]) regs_model[i] = '0;
      foreach (mem_model[i]) mem_model[i] = '0;
      len_model = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) len_model = cfg_wdata;
      if (out_valid && out_ready) begin
        got = '{next_pc, print_valid, print_value, finished};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", got);
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        execute_instr(e);
        expected_q.push_back(e);
      end
    end
  end
endmodule

>>> tb/tb_dlx_subset_execute_unit.sv
// Top testbench: clock, reset, stimulus and verdict for the DLX-subset execute unit.
module tb_dlx_subset_execute_unit;
  import dlxeu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [5:0] command = '0;
  logic [4:0] dest_reg = '0, src_reg_a = '0, src_reg_b = '0;
  logic signed [31:0] immediate = '0;
  logic [1:0] target_mode = '0;
  logic [11:0] target_index = '0;
  logic print_from_register = 0;
  logic [7:0] byte_data = '0;
  logic signed [31:0] next_pc, print_value;
  logic print_valid, finished;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit hold_done = 0;
  localparam int CYCLE_LIMIT = 400000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dlx_subset_execute_unit dut (.*);
  dlxeu_checker chk (.*);

  // Abort on a runaway run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, plus one long hold-off once beats start flowing.
  initial begin
    int n;
    out_ready = 1;
    @(posedge clk iff (in_valid && in_ready));
    repeat (20) @(negedge clk);
    out_ready = 0;
    repeat (200) @(negedge clk);
    hold_done = 1;
    forever begin
      out_ready = 1;
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_ready = 0;
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  // Drive one instruction beat and hold it until accepted.
  task automatic send_instr(logic [5:0] c, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                            logic [31:0] imm, logic [1:0] tm, logic [11:0] ti,
                            logic pfr, logic [7:0] bd);
    command = c; dest_reg = rd; src_reg_a = ra; src_reg_b = rb;
    immediate = imm; target_mode = tm; target_index = ti;
    print_from_register = pfr; byte_data = bd;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic random_instr(bit busy);
    logic [5:0] c;
    logic [31:0] imm;
    int n;
    case ($urandom_range(0, 9))
      0: c = 6'($urandom_range(33, 63));
      1: c = CMD_PRELOAD;
      2, 3: c = 6'($urandom_range(CMD_LW, CMD_PRINT));
      default: c = 6'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 3))
      0: imm = $urandom;
      1: imm = 32'($urandom_range(0, 70000));
      2: imm = -32'($urandom_range(0, 8));
      default: imm = 32'($urandom_range(0, 31));
    endcase
    send_instr(c, 5'($urandom), 5'($urandom), 5'($urandom), imm, 2'($urandom),
               12'($urandom), 1'($urandom), 8'($urandom));
    if (!busy) begin
      n = gap_len();
      repeat (n) @(negedge clk);
    end
  endtask

  // Let the block drain before a configuration write.
  task automatic drain_and_config(logic [LEN_BITS-1:0] v);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
  endtask

  initial begin
    logic [LEN_BITS-1:0] lens [4] = '{13'd4096, 13'd0, 13'd1, 13'd4095};
    repeat (8) @(negedge clk);
    rst = 0;
    // Directed: extremes, every command, self-clear wrap and print modes.
    drain_and_config(13'd4096);
    send_instr(CMD_PRELOAD, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 8'hff);
    send_instr(CMD_PRELOAD, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 8'h81);
    send_instr(CMD_ADDI, 5'd1, 5'd0, 0, 32'h7fff_ffff, 0, 0, 0, 0);
    send_instr(CMD_ADDI, 5'd2, 5'd1, 0, 32'd1, 0, 0, 0, 0);
    send_instr(CMD_SLT, 5'd3, 5'd2, 5'd1, 0, 0, 0, 0, 0);
    for (int c = 0; c < 32; c++)
      send_instr(6'(c), 5'(c), 5'(31 - c), 5'(c + 7), 32'hffff_fffd - c,
                 2'(c), 12'hfff, 1'(c), 8'(c));
    send_instr(CMD_SW, 5'd1, 5'd0, 0, 32'h0000_fffe, 0, 0, 0, 0);
    send_instr(CMD_PRINT, 0, 5'd0, 0, 32'h0000_fffe, 0, 0, 1'b0, 0);
    send_instr(CMD_PRINT, 0, 5'd1, 0, 32'h0, 0, 0, 1'b1, 0);
    send_instr(6'd63, 5'h1f, 5'h1f, 5'h1f, 32'h8000_0000, 2'd3, 12'hfff, 1, 8'hff);
    // Random phases across several program lengths; phase 0 rides the hold-off.
    for (int p = 0; p < 4; p++) begin
      drain_and_config(p == 3 ? 13'($urandom_range(0, 8191)) : lens[p]);
      for (int i = 0; i < 235; i++) random_instr(p == 0 && !hold_done);
    end
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
